[sv/tst_pkg.sv]
// Shared types, constants and codes for the timer slot table.
package tst_pkg;

	localparam int SLOTS   = 32;
	localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int TIME_W  = 64;
	localparam int SLOT_W  = 8;
	localparam int RSLOT_W = 6;
	localparam int FUNC_W  = 3;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [TIME_W-1:0] time_t;

	typedef enum logic [FUNC_W-1:0] {
		FN_ADD    = 3'd0,
		FN_REMOVE = 3'd1,
		FN_UPDATE = 3'd2,
		FN_ENABLE = 3'd3,
		FN_DISABLE = 3'd4,
		FN_QUERY  = 3'd5,
		FN_CHECK  = 3'd6
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FAIL  = 2'd1,
		ST_FIRED = 2'd2,
		ST_NONE  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_CHK,
		S_CHK_END,
		S_CHK_FIN
	} state_t;

	typedef enum logic [2:0] {
		FL_NOP,
		FL_SET_USED,
		FL_CLR_USED,
		FL_SET_EN,
		FL_CLR_EN
	} flag_op_t;

	typedef struct packed {
		flag_op_t op;
		idx_t     idx;
	} flag_cmd_t;

endpackage

[sv/tst_expiry_mem.sv]
// Expiry time store: one write port, one registered read port.
module tst_expiry_mem import tst_pkg::*; (
	input  logic  clk,
	input  logic  we,
	input  idx_t  waddr,
	input  time_t wdata,
	input  idx_t  raddr,
	output time_t rdata
);

	time_t mem [SLOTS];
	time_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/tst_flags.sv]
// Used and enabled bits of every slot, one update per cycle.
module tst_flags import tst_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  flag_cmd_t        cmd,
	output logic [SLOTS-1:0] used,
	output logic [SLOTS-1:0] enabled
);

	logic [SLOTS-1:0] used_q;
	logic [SLOTS-1:0] enabled_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			enabled_q <= '0;
		end else begin
			case (cmd.op)
				FL_SET_USED: used_q[cmd.idx]    <= 1'b1;
				FL_CLR_USED: used_q[cmd.idx]    <= 1'b0;
				FL_SET_EN:   enabled_q[cmd.idx] <= 1'b1;
				FL_CLR_EN:   enabled_q[cmd.idx] <= 1'b0;
				default: begin
				end
			endcase
		end
	end

	assign used    = used_q;
	assign enabled = enabled_q;

endmodule

[sv/timer_slot_table.sv]
// Timer slot table top level: command sequencer, result register, slot scans.
// Sequence: single-result requests answer in the cycle after acceptance; add tests one slot
//   per cycle from slot 0 until a free one or the last; check reads one expiry per slot, then
//   a compare stage, S_CHK_END and S_CHK_FIN. The receiver cannot stall: results strobe once.
// Throughput: a single-result request every cycle; add and check hold busy during their scan.
// Reset (arst_n low) clears all used and enabled bits; expiries are not cleared, only used slots fire.
module timer_slot_table import tst_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [FUNC_W-1:0]  func,
	input  logic [SLOT_W-1:0]  slot,
	input  logic [TIME_W-1:0]  time_value,
	output logic               strobe,
	output logic [1:0]         status,
	output logic [RSLOT_W-1:0] result_slot,
	output logic               is_enabled,
	output logic [TIME_W-1:0]  fire_time,
	output logic               last
);

	localparam idx_t IDX_LAST = idx_t'(SLOTS - 1);

	state_t state_q, state_d;

	// scan counter and the time captured with the request
	idx_t  cnt_q, cnt_d;
	time_t t_q, t_d;

	// compare stage behind the memory read
	logic s1_v_s1;
	idx_t idx_s1;

	// a fired slot held back until we know whether it is the last
	logic pend_q, pend_d;
	idx_t pend_slot_q, pend_slot_d;

	// result register
	logic    strobe_q, strobe_d;
	status_t status_q, status_d;
	idx_t    rslot_q, rslot_d;
	logic    en_q, en_d;
	time_t   ft_q, ft_d;
	logic    last_q, last_d;

	flag_cmd_t        flag_cmd;
	logic [SLOTS-1:0] used_vec;
	logic [SLOTS-1:0] en_vec;

	logic  mem_we;
	idx_t  mem_waddr;
	time_t mem_wdata;
	time_t mem_rdata;

	logic  accept;
	logic  slot_ok;
	idx_t  slot_idx;
	logic  hit;
	func_t fn;

	tst_flags u_flags (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (flag_cmd),
		.used    (used_vec),
		.enabled (en_vec)
	);

	tst_expiry_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (cnt_q),
		.rdata (mem_rdata)
	);

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign fn       = func_t'(func);
	assign slot_ok  = (slot < SLOT_W'(SLOTS));
	assign slot_idx = slot[IDX_W-1:0];

	// slot in the compare stage is due: used, enabled and expiry not after now
	assign hit = s1_v_s1 && used_vec[idx_s1] && en_vec[idx_s1] && (mem_rdata <= t_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && fn == FN_ADD) begin
					state_d = S_ADD;
				end else if (accept && fn == FN_CHECK) begin
					state_d = S_CHK;
				end
			end
			S_ADD: begin
				if (!used_vec[cnt_q] || cnt_q == IDX_LAST) begin
					state_d = S_IDLE;
				end
			end
			S_CHK: begin
				if (cnt_q == IDX_LAST) begin
					state_d = S_CHK_END;
				end
			end
			S_CHK_END: state_d = S_CHK_FIN;
			S_CHK_FIN: state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// actions and result
	always_comb begin
		cnt_d         = cnt_q;
		t_d           = t_q;
		pend_d        = pend_q;
		pend_slot_d   = pend_slot_q;
		flag_cmd.op   = FL_NOP;
		flag_cmd.idx  = slot_idx;
		mem_we        = 1'b0;
		mem_waddr     = slot_idx;
		mem_wdata     = time_value;
		strobe_d      = 1'b0;
		status_d      = ST_OK;
		rslot_d       = '0;
		en_d          = 1'b0;
		ft_d          = '0;
		last_d        = 1'b1;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					t_d    = time_value;
					cnt_d  = '0;
					pend_d = 1'b0;
					case (fn)
						FN_ADD, FN_CHECK: begin
						end
						FN_REMOVE, FN_UPDATE, FN_ENABLE, FN_DISABLE: begin
							strobe_d = 1'b1;
							if (slot_ok && used_vec[slot_idx]) begin
								case (fn)
									FN_REMOVE: begin
										flag_cmd.op = FL_CLR_USED;
										mem_we      = 1'b1;
										mem_wdata   = '0;
									end
									FN_UPDATE: mem_we      = 1'b1;
									FN_ENABLE: flag_cmd.op = FL_SET_EN;
									default:   flag_cmd.op = FL_CLR_EN;
								endcase
							end else begin
								status_d = ST_FAIL;
							end
						end
						FN_QUERY: begin
							strobe_d = 1'b1;
							en_d     = slot_ok && en_vec[slot_idx];
						end
						default: begin
							strobe_d = 1'b1;
							status_d = ST_FAIL;
						end
					endcase
				end
			end
			S_ADD: begin
				flag_cmd.idx = cnt_q;
				mem_waddr    = cnt_q;
				mem_wdata    = t_q;
				if (!used_vec[cnt_q]) begin
					flag_cmd.op = FL_SET_USED;
					mem_we      = 1'b1;
					strobe_d    = 1'b1;
					rslot_d     = cnt_q;
				end else if (cnt_q == IDX_LAST) begin
					strobe_d = 1'b1;
					status_d = ST_FAIL;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_CHK, S_CHK_END: begin
				if (state_q == S_CHK && cnt_q != IDX_LAST) begin
					cnt_d = cnt_q + 1'b1;
				end
				if (hit) begin
					flag_cmd.op  = FL_CLR_EN;
					flag_cmd.idx = idx_s1;
					pend_d       = 1'b1;
					pend_slot_d  = idx_s1;
					// a new hit proves the held one is not the last
					if (pend_q) begin
						strobe_d = 1'b1;
						status_d = ST_FIRED;
						rslot_d  = pend_slot_q;
						ft_d     = t_q;
						last_d   = 1'b0;
					end
				end
			end
			S_CHK_FIN: begin
				strobe_d = 1'b1;
				if (pend_q) begin
					status_d = ST_FIRED;
					rslot_d  = pend_slot_q;
					ft_d     = t_q;
				end else begin
					status_d = ST_NONE;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			s1_v_s1  <= 1'b0;
			pend_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			s1_v_s1  <= (state_q == S_CHK);
			pend_q   <= pend_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		cnt_q       <= cnt_d;
		t_q         <= t_d;
		idx_s1      <= cnt_q;
		pend_slot_q <= pend_slot_d;
		status_q    <= status_d;
		rslot_q     <= rslot_d;
		en_q        <= en_d;
		ft_q        <= ft_d;
		last_q      <= last_d;
	end

	assign strobe      = strobe_q;
	assign status      = status_q;
	assign result_slot = RSLOT_W'(rslot_q);
	assign is_enabled  = en_q;
	assign fire_time   = ft_q;
	assign last        = last_q;

	// nothing left in the compare stage once the block reports idle
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !s1_v_s1)
		else $error("compare stage busy while idle");

	// single-result requests answer on the next cycle, marked last
	a_single_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && fn != FN_ADD && fn != FN_CHECK) |=> (strobe && last))
		else $error("single-result request not answered");

	// a fired result that is not the last must be followed by more of the check
	a_more_to_come: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status == ST_FIRED && !last) |-> busy)
		else $error("non-final fired result after check ended");

	// the expiry store is never written during a check scan
	a_no_write_in_check: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_IDLE || state_q == S_ADD))
		else $error("expiry write during check");

endmodule

[tb/tb.sv]
// Self-checking testbench for the timer slot table: request driver, result monitor, predictor.
module tb;
	import tst_pkg::*;

	// func value with no command behind it; the block must answer it with a failure
	localparam logic [FUNC_W-1:0] FN_UNASSIGNED = 3'd7;
	localparam time_t T_MAX = {TIME_W{1'b1}};

	// one request as the driver presents it, with the idle cycles to wait before it
	typedef struct {
		logic [FUNC_W-1:0] code;
		logic [SLOT_W-1:0] slot_no;
		time_t             t;
		int                gap;
	} request_t;

	// one result as the block should strobe it
	typedef struct {
		status_t            status;
		logic [RSLOT_W-1:0] slot_no;
		logic               enabled;
		time_t              fired_at;
		logic               last_flag;
	} outcome_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [FUNC_W-1:0]  func = '0;
	logic [SLOT_W-1:0]  slot = '0;
	logic [TIME_W-1:0]  time_value = '0;
	logic               strobe;
	logic [1:0]         status;
	logic [RSLOT_W-1:0] result_slot;
	logic               is_enabled;
	logic [TIME_W-1:0]  fire_time;
	logic               last;

	timer_slot_table dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .slot(slot), .time_value(time_value),
		.strobe(strobe), .status(status), .result_slot(result_slot),
		.is_enabled(is_enabled), .fire_time(fire_time), .last(last)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Predictor state: the slot table as the block should hold it.
	bit    slot_used    [SLOTS];
	bit    slot_enabled [SLOTS];
	time_t slot_expiry  [SLOTS];

	request_t pending_requests[$];  // filled up front, drained by the driver
	outcome_t due_results[$];       // oldest first, matched against each strobe
	int       mismatches = 0;
	bit       took = 1'b0;          // request accepted at the last rising edge
	bit       calm = 1'b0;          // while set, requests go back to back
	int       hold_left = 0;
	bit       hold_loaded = 1'b0;

	// Works out every result one accepted request causes and queues them in order.
	function automatic void predict_table(request_t r);
		outcome_t o;
		bit          in_range;
		bit          found;
		int unsigned idx;
		int          fired;
		o = '{status: ST_OK, slot_no: '0, enabled: 1'b0, fired_at: '0, last_flag: 1'b1};
		in_range = (r.slot_no < SLOTS);
		idx = in_range ? r.slot_no : 0;
		found = 1'b0;
		fired = 0;
		case (r.code)
		FN_ADD: begin
			// lowest free slot wins; enabled bit untouched
			o.status = ST_FAIL;
			for (int i = 0; i < SLOTS; i++) begin
				if (!found && !slot_used[i]) begin
					found = 1'b1;
					slot_used[i] = 1'b1;
					slot_expiry[i] = r.t;
					o.status = ST_OK;
					o.slot_no = RSLOT_W'(i);
				end
			end
			due_results.push_back(o);
		end
		FN_REMOVE, FN_UPDATE, FN_ENABLE, FN_DISABLE: begin
			if (!in_range || !slot_used[idx]) begin
				o.status = ST_FAIL;
			end else begin
				case (r.code)
				FN_REMOVE: begin
					slot_used[idx] = 1'b0;
					slot_expiry[idx] = '0;
				end
				FN_UPDATE: slot_expiry[idx] = r.t;
				FN_ENABLE: slot_enabled[idx] = 1'b1;
				default:   slot_enabled[idx] = 1'b0;
				endcase
			end
			due_results.push_back(o);
		end
		FN_QUERY: begin
			// reads even an unused slot; out of range reads as not enabled
			o.enabled = in_range ? slot_enabled[idx] : 1'b0;
			due_results.push_back(o);
		end
		FN_CHECK: begin
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_used[i] && slot_enabled[i] && slot_expiry[i] <= r.t) begin
					slot_enabled[i] = 1'b0;
					o.status = ST_FIRED;
					o.slot_no = RSLOT_W'(i);
					o.fired_at = r.t;
					o.last_flag = 1'b0;
					due_results.push_back(o);
					fired++;
				end
			end
			if (fired == 0) begin
				o.status = ST_NONE;
				due_results.push_back(o);
			end else begin
				due_results[due_results.size() - 1].last_flag = 1'b1;
			end
		end
		default: begin
			o.status = ST_FAIL;
			due_results.push_back(o);
		end
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [TIME_W-1:0] want,
			logic [TIME_W-1:0] got);
		$display("tb: mismatch on %s: expected %0h, got %0h at %0t", what, want, got, $time);
		mismatches++;
	endtask

	task automatic queue_request(logic [FUNC_W-1:0] code, logic [SLOT_W-1:0] slot_no,
			time_t t);
		request_t r;
		r.code = code;
		r.slot_no = slot_no;
		r.t = t;
		r.gap = calm ? 0 : $urandom_range(0, 19);
		pending_requests.push_back(r);
	endtask

	// Driver: inputs move on the falling edge only. start gets one assignment per step,
	// so a request that follows straight on keeps it high without a glitch.
	always @(negedge clk) begin : drive_requests
		request_t r;
		logic     nxt;
		nxt = start;
		if (arst_n && (!start || took)) begin
			nxt = 1'b0;
			if (pending_requests.size() != 0) begin
				if (!hold_loaded) begin
					hold_left = pending_requests[0].gap;
					hold_loaded = 1'b1;
				end
				if (hold_left > 0) begin
					hold_left--;
				end else begin
					r = pending_requests.pop_front();
					func <= r.code;
					slot <= r.slot_no;
					time_value <= r.t;
					nxt = 1'b1;
					hold_loaded = 1'b0;
				end
			end
		end
		start <= nxt;
	end

	// Monitor: acceptance and results are both seen at the rising edge, before the
	// block's own registers move. New expectations go to the back of the queue, so
	// a result for the previous request strobed at the same edge still meets its own.
	always @(posedge clk) begin : watch_results
		request_t r;
		outcome_t o;
		if (arst_n) begin
			took = start && !busy;
			if (took) begin
				r.code = func;
				r.slot_no = slot;
				r.t = time_value;
				r.gap = 0;
				predict_table(r);
			end
			if (strobe) begin
				if (due_results.size() == 0) begin
					report_mismatch("result with nothing due (status)", '0,
						TIME_W'(status));
				end else begin
					o = due_results.pop_front();
					if (status !== o.status)
						report_mismatch("status", TIME_W'(o.status), TIME_W'(status));
					if (result_slot !== o.slot_no)
						report_mismatch("result_slot", TIME_W'(o.slot_no),
							TIME_W'(result_slot));
					if (is_enabled !== o.enabled)
						report_mismatch("is_enabled", TIME_W'(o.enabled),
							TIME_W'(is_enabled));
					if (fire_time !== o.fired_at)
						report_mismatch("fire_time", o.fired_at, fire_time);
					if (last !== o.last_flag)
						report_mismatch("last", TIME_W'(o.last_flag), TIME_W'(last));
				end
			end
		end
	end

	// Stimulus and end of run.
	initial begin : run_stimulus
		time_t base;
		int    pick;
		int    sl;
		time_t t;
		logic [FUNC_W-1:0] code;

		// Directed: empty table, failures on unused and out-of-range slots, expiry
		// equal to the time, expiry one past it, time extremes, enabled bit kept over
		// remove and add, unassigned command.
		queue_request(FN_QUERY, 8'd0, '0);
		queue_request(FN_CHECK, 8'd0, '0);
		queue_request(FN_REMOVE, 8'd0, '0);
		queue_request(FN_UPDATE, 8'd5, T_MAX);
		queue_request(FN_ENABLE, 8'd5, '0);
		queue_request(FN_DISABLE, 8'd5, '0);
		queue_request(FN_ADD, 8'd255, '0);
		queue_request(FN_QUERY, 8'd255, T_MAX);
		queue_request(FN_ENABLE, 8'd0, '0);
		queue_request(FN_QUERY, 8'd0, '0);
		queue_request(FN_CHECK, 8'd0, '0);           // fires: expiry equals time
		queue_request(FN_CHECK, 8'd0, T_MAX);        // already disabled
		queue_request(FN_UPDATE, 8'd0, T_MAX);
		queue_request(FN_ENABLE, 8'd0, '0);
		queue_request(FN_CHECK, 8'd0, T_MAX - 1);    // expiry after the time
		queue_request(FN_CHECK, 8'd0, T_MAX);
		queue_request(FN_ENABLE, 8'd32, '0);         // first slot out of range
		queue_request(FN_REMOVE, 8'd255, '0);
		queue_request(FN_UNASSIGNED, 8'd0, T_MAX);
		queue_request(FN_ENABLE, 8'd0, '0);
		queue_request(FN_REMOVE, 8'd0, '0);
		queue_request(FN_QUERY, 8'd0, '0);           // unused but still enabled
		queue_request(FN_ADD, 8'd0, 64'd7);          // reclaims slot 0, still enabled
		queue_request(FN_DISABLE, 8'd0, '0);
		queue_request(FN_CHECK, 8'd0, 64'd7);

		// Random: expiries and check times cluster round a moving base so that
		// checks fire; a few requests carry fully random times and slots as noise.
		base = '0;
		for (int n = 0; n < 405; n++) begin
			if (n % 45 == 0) begin
				calm = ((n / 45) % 3 == 2);
				case ($urandom_range(0, 3))
				0:       base = TIME_W'($urandom_range(0, 50));
				1:       base = T_MAX - $urandom_range(0, 400);
				default: base = {$urandom, $urandom};
				endcase
			end
			if (n == 200) begin
				// fill the table and go past it
				for (int k = 0; k < SLOTS + 2; k++)
					queue_request(FN_ADD, SLOT_W'($urandom_range(0, 255)),
						base + $urandom_range(0, 300));
				n += SLOTS + 1;
				continue;
			end
			pick = $urandom_range(0, 99);
			if (pick < 25)      code = FN_ADD;
			else if (pick < 45) code = FN_ENABLE;
			else if (pick < 60) code = FN_CHECK;
			else if (pick < 70) code = FN_UPDATE;
			else if (pick < 78) code = FN_REMOVE;
			else if (pick < 86) code = FN_DISABLE;
			else if (pick < 98) code = FN_QUERY;
			else                code = FN_UNASSIGNED;
			sl = ($urandom_range(0, 99) < 85) ? $urandom_range(0, SLOTS - 1)
			                                  : $urandom_range(0, 255);
			if (code == FN_ADD || code == FN_UPDATE) begin
				t = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
				                                : base + $urandom_range(0, 300);
			end else if (code == FN_CHECK) begin
				t = base + $urandom_range(0, 300);
				base = base + $urandom_range(0, 60);
			end else begin
				t = {$urandom, $urandom};
			end
			queue_request(code, SLOT_W'(sl), t);
		end

		// reset held, then released away from the rising edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || start) @(posedge clk);
		while (due_results.size() != 0) @(posedge clk);
		// let any stray result of a check scan show itself
		repeat (SLOTS + 8) @(posedge clk);
		if (mismatches == 0 && due_results.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run (every gap at its longest,
	// every check at its full scan and result count).
	initial begin : watchdog
		#(12 * 400000);
		$display("tb: FAIL");
		$finish;
	end

endmodule

[timer_slot_table.f]
sv/tst_pkg.sv
sv/tst_expiry_mem.sv
sv/tst_flags.sv
sv/timer_slot_table.sv
tb/tb.sv
